>>> rtl/wib_pkg.sv
// ----------------------------------------------------------------------------
// wib_pkg
// Shared types, widths and saturating helpers for the windowed income bank.
// ----------------------------------------------------------------------------
package wib_pkg;

   localparam int FUNC_W = 2;
   localparam int AMT_W  = 16;
   localparam int BAL_W  = 32;
   localparam int BIN_W  = 24;
   localparam int RATE_W = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT  = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_ADD   = 2'd2,
      FUNC_SPEND = 2'd3
   } func_type;

   // first stage: balances and folded window totals
   typedef struct packed {
      func_type           func;
      logic               granted;
      logic [BAL_W-1:0]   mineral_bal;
      logic [BAL_W-1:0]   gas_bal;
      logic [BAL_W-1:0]   mineral_fold;
      logic [BAL_W-1:0]   gas_fold;
   } stage1_type;

   // second stage: reciprocal partial products
   typedef struct packed {
      func_type           func;
      logic               granted;
      logic [BAL_W-1:0]   mineral_bal;
      logic [BAL_W-1:0]   gas_bal;
      logic [BAL_W+21-1:0] mineral_lo;
      logic [BAL_W+21-1:0] mineral_hi;
      logic [BAL_W+21-1:0] gas_lo;
      logic [BAL_W+21-1:0] gas_hi;
   } stage2_type;

   function automatic logic [BAL_W-1:0] sat_add_bal(input logic [BAL_W-1:0] a,
                                                    input logic [BAL_W-1:0] b);
      logic [BAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BAL_W] ? '1 : s[BAL_W-1:0];
   endfunction

   function automatic logic [BIN_W-1:0] sat_add_bin(input logic [BIN_W-1:0] a,
                                                    input logic [AMT_W-1:0] b);
      logic [BIN_W:0] s;
      s = {1'b0, a} + {{(BIN_W-AMT_W+1){1'b0}}, b};
      return s[BIN_W] ? '1 : s[BIN_W-1:0];
   endfunction

   function automatic logic [BAL_W-1:0] floor_sub_bin(input logic [BAL_W-1:0] a,
                                                      input logic [BIN_W-1:0] b);
      logic [BAL_W-1:0] bw;
      bw = {{(BAL_W-BIN_W){1'b0}}, b};
      return (a > bw) ? a - bw : '0;
   endfunction

endpackage

>>> rtl/wib_req_if.sv
// ----------------------------------------------------------------------------
// wib_req_if
// Request channel: one item kind and two amounts per word.
// ----------------------------------------------------------------------------
interface wib_req_if
   import wib_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [AMT_W-1:0]   mineral_amount;
   logic [AMT_W-1:0]   gas_amount;

   modport source (output valid, func, mineral_amount, gas_amount, input ready);
   modport sink   (input valid, func, mineral_amount, gas_amount, output ready);
endinterface

>>> rtl/wib_rsp_if.sv
// ----------------------------------------------------------------------------
// wib_rsp_if
// Response channel: grant flag, balances and latched rates per word.
// ----------------------------------------------------------------------------
interface wib_rsp_if
   import wib_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               granted;
   logic [BAL_W-1:0]   mineral_balance;
   logic [BAL_W-1:0]   gas_balance;
   logic [RATE_W-1:0]  mineral_rate;
   logic [RATE_W-1:0]  gas_rate;

   modport source (output valid, granted, mineral_balance, gas_balance,
                   mineral_rate, gas_rate, input ready);
   modport sink   (input valid, granted, mineral_balance, gas_balance,
                   mineral_rate, gas_rate, output ready);
endinterface

>>> rtl/windowed_income_bank_unit.sv
// ----------------------------------------------------------------------------
// windowed_income_bank_unit
// Two-channel credit account with a sliding-window income meter.
// ----------------------------------------------------------------------------
// Accepts one word per clock unless the response side stalls, and returns
// one response word per request word, in order, through the s1, s2 and
// response registers. Balances, the current frame bin and the window
// totals update at acceptance; the rate (total * 256 / WINDOW_LENGTH) is
// formed by a reciprocal multiply split into two partial products, hence
// three pipeline stages. The current bin lives in a register; past bins sit
// in a WINDOW_LENGTH-deep memory written once per tick, with the oldest bin
// prefetched through its registered read port. Init takes effect at once:
// bins not written since the last init or reset read as zero.
// ----------------------------------------------------------------------------
module windowed_income_bank_unit
   import wib_pkg::*;
#(
   parameter int WINDOW_LENGTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   wib_req_if.sink      req_ch,
   wib_rsp_if.source    rsp_ch
);

   localparam int IDX_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int LOG_W = $clog2(WINDOW_LENGTH);
   // ceil(2^(40+LOG_W) / W): exact quotient for any 40-bit dividend
   localparam logic [63:0] RECIP = ((64'd1 << (40 + LOG_W)) + 64'(WINDOW_LENGTH) - 64'd1)
                                   / 64'(WINDOW_LENGTH);
   localparam int M_LO_W = 21;
   localparam int M_HI_W = 21;
   localparam logic [M_LO_W-1:0] M_LO = RECIP[M_LO_W-1:0];
   localparam logic [M_HI_W-1:0] M_HI = RECIP[M_LO_W+M_HI_W-1:M_LO_W];
   localparam int PROD_W  = BAL_W + M_LO_W;
   localparam int SUM_W   = BAL_W + M_LO_W + M_HI_W;
   localparam int SHIFT   = 32 + LOG_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LENGTH - 1);

   function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [RATE_W-1:0] rate_of(input logic [PROD_W-1:0] lo,
                                                 input logic [PROD_W-1:0] hi);
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] q;
      s = {{(SUM_W-PROD_W){1'b0}}, lo} + {hi, {M_LO_W{1'b0}}};
      q = s >> SHIFT;
      return (|q[SUM_W-1:RATE_W]) ? '1 : q[RATE_W-1:0];
   endfunction

   // account state
   logic [BAL_W-1:0]  mineral_bal_ff, mineral_bal_in;
   logic [BAL_W-1:0]  gas_bal_ff, gas_bal_in;
   logic [BAL_W-1:0]  mineral_total_ff, mineral_total_in;
   logic [BAL_W-1:0]  gas_total_ff, gas_total_in;
   logic [BIN_W-1:0]  mineral_cur_ff, mineral_cur_in;
   logic [BIN_W-1:0]  gas_cur_ff, gas_cur_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              wrapped_ff, wrapped_in;
   logic [RATE_W-1:0] mineral_rate_ff, mineral_rate_in;
   logic [RATE_W-1:0] gas_rate_ff, gas_rate_in;

   // bin memory with prefetched oldest entry
   logic [2*BIN_W-1:0] bin_mem [WINDOW_LENGTH];
   logic [2*BIN_W-1:0] oldest_ff;
   logic [2*BIN_W-1:0] bypass_ff;
   logic               hit_ff;
   logic               bin_we;
   logic [IDX_W-1:0]   rd_addr;
   logic [2*BIN_W-1:0] oldest;
   logic               oldest_ok;
   logic [BIN_W-1:0]   mineral_old, gas_old;

   // pipeline
   stage1_type        s1_ff, s1_in;
   stage2_type        s2_ff, s2_in;
   logic              v1_ff, v2_ff, v3_ff;
   logic              granted3_ff;
   logic [BAL_W-1:0]  mineral_bal3_ff, gas_bal3_ff;
   logic              rdy1, rdy2, rdy3;
   logic              accept;
   logic [BAL_W-1:0]  mineral_fold, gas_fold;
   logic [BAL_W-1:0]  mineral_amt, gas_amt;
   logic              granted;

   assign rdy3   = !v3_ff || rsp_ch.ready;
   assign rdy2   = !v2_ff || rdy3;
   assign rdy1   = !v1_ff || rdy2;
   assign accept = req_ch.valid && rdy1;
   assign req_ch.ready = rdy1;

   assign oldest      = hit_ff ? bypass_ff : oldest_ff;
   assign oldest_ok   = wrapped_ff || (idx_ff == IDX_LAST);
   assign mineral_old = oldest_ok ? oldest[2*BIN_W-1:BIN_W] : '0;
   assign gas_old     = oldest_ok ? oldest[BIN_W-1:0] : '0;
   assign mineral_fold = sat_add_bal(mineral_total_ff, {{(BAL_W-BIN_W){1'b0}}, mineral_cur_ff});
   assign gas_fold     = sat_add_bal(gas_total_ff, {{(BAL_W-BIN_W){1'b0}}, gas_cur_ff});
   assign mineral_amt  = {{(BAL_W-AMT_W){1'b0}}, req_ch.mineral_amount};
   assign gas_amt      = {{(BAL_W-AMT_W){1'b0}}, req_ch.gas_amount};

   always_comb begin
      mineral_bal_in   = mineral_bal_ff;
      gas_bal_in       = gas_bal_ff;
      mineral_total_in = mineral_total_ff;
      gas_total_in     = gas_total_ff;
      mineral_cur_in   = mineral_cur_ff;
      gas_cur_in       = gas_cur_ff;
      idx_in           = idx_ff;
      wrapped_in       = wrapped_ff;
      granted          = 1'b0;
      bin_we           = 1'b0;
      if (accept) begin
         case (func_type'(req_ch.func))
            FUNC_INIT: begin
               mineral_bal_in   = mineral_amt;
               gas_bal_in       = gas_amt;
               mineral_total_in = '0;
               gas_total_in     = '0;
               mineral_cur_in   = '0;
               gas_cur_in       = '0;
               idx_in           = '0;
               wrapped_in       = 1'b0;
            end
            FUNC_TICK: begin
               mineral_total_in = floor_sub_bin(mineral_fold, mineral_old);
               gas_total_in     = floor_sub_bin(gas_fold, gas_old);
               mineral_cur_in   = '0;
               gas_cur_in       = '0;
               idx_in           = step_idx(idx_ff);
               wrapped_in       = oldest_ok;
               bin_we           = 1'b1;
            end
            FUNC_ADD: begin
               mineral_bal_in = sat_add_bal(mineral_bal_ff, mineral_amt);
               gas_bal_in     = sat_add_bal(gas_bal_ff, gas_amt);
               mineral_cur_in = sat_add_bin(mineral_cur_ff, req_ch.mineral_amount);
               gas_cur_in     = sat_add_bin(gas_cur_ff, req_ch.gas_amount);
            end
            FUNC_SPEND: begin
               if (mineral_bal_ff >= mineral_amt && gas_bal_ff >= gas_amt) begin
                  mineral_bal_in = mineral_bal_ff - mineral_amt;
                  gas_bal_in     = gas_bal_ff - gas_amt;
                  granted        = 1'b1;
               end
            end
            default: begin
               granted = 1'b0;
            end
         endcase
      end
   end

   assign rd_addr = step_idx(idx_in);

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[idx_ff] <= {mineral_cur_ff, gas_cur_ff};
      end
      oldest_ff <= bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      hit_ff    <= bin_we && (rd_addr == idx_ff);
      bypass_ff <= {mineral_cur_ff, gas_cur_ff};
   end

   always_comb begin
      s1_in.func         = func_type'(req_ch.func);
      s1_in.granted      = granted;
      s1_in.mineral_bal  = mineral_bal_in;
      s1_in.gas_bal      = gas_bal_in;
      s1_in.mineral_fold = mineral_fold;
      s1_in.gas_fold     = gas_fold;

      s2_in.func         = s1_ff.func;
      s2_in.granted      = s1_ff.granted;
      s2_in.mineral_bal  = s1_ff.mineral_bal;
      s2_in.gas_bal      = s1_ff.gas_bal;
      s2_in.mineral_lo   = PROD_W'(s1_ff.mineral_fold) * PROD_W'(M_LO);
      s2_in.mineral_hi   = PROD_W'(s1_ff.mineral_fold) * PROD_W'(M_HI);
      s2_in.gas_lo       = PROD_W'(s1_ff.gas_fold) * PROD_W'(M_LO);
      s2_in.gas_hi       = PROD_W'(s1_ff.gas_fold) * PROD_W'(M_HI);

      mineral_rate_in = mineral_rate_ff;
      gas_rate_in     = gas_rate_ff;
      case (s2_ff.func)
         FUNC_INIT: begin
            mineral_rate_in = '0;
            gas_rate_in     = '0;
         end
         FUNC_TICK: begin
            mineral_rate_in = rate_of(s2_ff.mineral_lo, s2_ff.mineral_hi);
            gas_rate_in     = rate_of(s2_ff.gas_lo, s2_ff.gas_hi);
         end
         default: begin
            mineral_rate_in = mineral_rate_ff;
            gas_rate_in     = gas_rate_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mineral_bal_ff   <= '0;
         gas_bal_ff       <= '0;
         mineral_total_ff <= '0;
         gas_total_ff     <= '0;
         mineral_cur_ff   <= '0;
         gas_cur_ff       <= '0;
         idx_ff           <= '0;
         wrapped_ff       <= 1'b0;
         mineral_rate_ff  <= '0;
         gas_rate_ff      <= '0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
      end else begin
         mineral_bal_ff   <= mineral_bal_in;
         gas_bal_ff       <= gas_bal_in;
         mineral_total_ff <= mineral_total_in;
         gas_total_ff     <= gas_total_in;
         mineral_cur_ff   <= mineral_cur_in;
         gas_cur_ff       <= gas_cur_in;
         idx_ff           <= idx_in;
         wrapped_ff       <= wrapped_in;
         if (rdy1) begin
            v1_ff <= req_ch.valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
            if (v2_ff) begin
               mineral_rate_ff <= mineral_rate_in;
               gas_rate_ff     <= gas_rate_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         granted3_ff     <= s2_ff.granted;
         mineral_bal3_ff <= s2_ff.mineral_bal;
         gas_bal3_ff     <= s2_ff.gas_bal;
      end
   end

   assign rsp_ch.valid           = v3_ff;
   assign rsp_ch.granted         = granted3_ff;
   assign rsp_ch.mineral_balance = mineral_bal3_ff;
   assign rsp_ch.gas_balance     = gas_bal3_ff;
   assign rsp_ch.mineral_rate    = mineral_rate_ff;
   assign rsp_ch.gas_rate        = gas_rate_ff;

endmodule
